// File: rtl/tilt_complementary_filter_assert.svh
// ============================================================================
// Tilt complementary filter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH

// Same-cycle implication
`define TCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcf check failed");

// Next-cycle implication
`define TCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcf check failed");

`endif

// File: rtl/tcf_pkg.sv
// ============================================================================
// Tilt complementary filter package
// Word types, fixed-point constants and the CORDIC arctangent table.
// ============================================================================
package tcf_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 16;
    localparam int ANGLE_W   = 16;
    localparam int CORD_W    = 34;   // CORDIC x/y, vector scaled by 2^14
    localparam int Z_W       = 21;   // CORDIC angle, Q.16 radians
    localparam int ACC_SHIFT = 14;
    localparam int ATAN_IDX_W = 5;

    // Fixed-point constants
    localparam logic signed [Z_W-1:0] PI_Q16 = 21'sd205887;
    localparam int INV_K_Q16   = 39797;
    localparam int ANGLE_LIMIT = 25736;
    localparam int ALPHA_ONE   = 65536;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int BLEND_W     = 17;
    localparam int GAIN_W      = 32;
    localparam logic [BLEND_W-1:0] BLEND_RESET = 17'd3277;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'd4687620;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLEND_WEIGHT = 1'b0,
        REG_GYRO_GAIN    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
    } sample_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
    } angle_word_t;

    // CORDIC status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in Q.16 radians, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 21'sd51472;
            5'd1:    val = 21'sd30386;
            5'd2:    val = 21'sd16055;
            5'd3:    val = 21'sd8150;
            5'd4:    val = 21'sd4091;
            5'd5:    val = 21'sd2047;
            5'd6:    val = 21'sd1024;
            5'd7:    val = 21'sd512;
            5'd8:    val = 21'sd256;
            5'd9:    val = 21'sd128;
            5'd10:   val = 21'sd64;
            5'd11:   val = 21'sd32;
            5'd12:   val = 21'sd16;
            5'd13:   val = 21'sd8;
            5'd14:   val = 21'sd4;
            5'd15:   val = 21'sd2;
            5'd16:   val = 21'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/tcf_stream_if.sv
// ============================================================================
// Tilt complementary filter stream interface
// Valid/ready channel carrying one word of a given payload type.
// ============================================================================
interface tcf_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tcf_cordic.sv
// ============================================================================
// Tilt complementary filter CORDIC
// Iterative vectoring CORDIC: atan2(y, x) and gain-scaled magnitude, one
// micro-rotation per cycle.
// ============================================================================
module tcf_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tcf_pkg::CORD_W-1:0]    x_in,
    input  logic signed [tcf_pkg::CORD_W-1:0]    y_in,
    output logic signed [tcf_pkg::Z_W-1:0]       angle,
    output logic signed [tcf_pkg::CORD_W-1:0]    mag,
    output tcf_pkg::cordic_stat_t                stat
);
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                              busy_reg, done_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic signed [tcf_pkg::CORD_W-1:0] x_reg, y_reg;
    logic signed [tcf_pkg::Z_W-1:0]    z_reg;
    logic                              zero_reg;
    logic                              last;
    logic signed [tcf_pkg::CORD_W-1:0] dx, dy;
    logic signed [tcf_pkg::Z_W-1:0]    step_angle;

    assign last       = (cnt_reg == CNT_W'(STEPS - 1));
    assign dx         = y_reg >>> cnt_reg;
    assign dy         = x_reg >>> cnt_reg;
    assign step_angle = tcf_pkg::atan_q16(tcf_pkg::ATAN_IDX_W'(cnt_reg));

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (last)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Pre-rotate into the right half plane, then rotate toward y = 0
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg <= -x_in;
                y_reg <= -y_in;
                z_reg <= (y_in >= 0) ? tcf_pkg::PI_Q16 : -tcf_pkg::PI_Q16;
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step_angle;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step_angle;
            end
        end
    end

    // Zero vector gives angle and magnitude zero
    assign angle     = zero_reg ? '0 : z_reg;
    assign mag       = zero_reg ? '0 : x_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/tilt_complementary_filter.sv
// ============================================================================
// Tilt complementary filter
// Roll and pitch from one accelerometer/gyro word, blended with gyro
// integration and kept as Q3.13 radian estimates.
// ============================================================================
// One word is taken at a time. The work goes to two passes through the
// single iterative CORDIC (roll, then pitch against the roll magnitude),
// with a start state between them, seven passes through the one shared
// 34 x 21 bit multiplier (magnitude scaling, then gain scaling and blending
// per axis), and a delivery state. The result sits in an output register,
// so a new word is accepted while it waits to be taken; the block only
// holds in its delivery state if the previous result is still pending.
`include "tilt_complementary_filter_assert.svh"

module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    tcf_stream_if.sink                             sample,
    tcf_stream_if.source                           result,
    input  logic                                   cfg_we,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]         cfg_data
);
    localparam int MUL_A_W = tcf_pkg::CORD_W;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int GYRO_W  = 21;
    localparam int GYRO_SHIFT = 29;
    localparam int MIX_SHIFT  = 19;
    localparam int DEN_SHIFT  = 16;
    localparam logic signed [PROD_W-1:0] GYRO_RND = PROD_W'(64'd1 << (GYRO_SHIFT - 1));
    localparam logic signed [PROD_W-1:0] MIX_RND  = PROD_W'(64'd1 << (MIX_SHIFT - 1));
    localparam logic signed [PROD_W-1:0] MIX_MAX  = PROD_W'(tcf_pkg::ANGLE_LIMIT);
    localparam logic signed [PROD_W-1:0] MIX_MIN  = -MIX_MAX;
    localparam logic signed [tcf_pkg::ANGLE_W-1:0] OUT_MAX =
        tcf_pkg::ANGLE_W'(tcf_pkg::ANGLE_LIMIT);
    localparam logic signed [tcf_pkg::ANGLE_W-1:0] OUT_MIN = -OUT_MAX;

    typedef enum logic [9:0] {
        ST_IDLE         = 10'b0000000001,
        ST_ROLL_CORDIC  = 10'b0000000010,
        ST_PITCH_START  = 10'b0000000100,
        ST_PITCH_CORDIC = 10'b0000001000,
        ST_GYRO_MUL     = 10'b0000010000,
        ST_GYRO_SUM     = 10'b0000100000,
        ST_MIX_GYRO     = 10'b0001000000,
        ST_MIX_ACC      = 10'b0010000000,
        ST_FINISH       = 10'b0100000000,
        ST_DELIVER      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg;   // 0: roll, 1: pitch

    logic [tcf_pkg::BLEND_W-1:0] blend_reg;
    logic [tcf_pkg::GAIN_W-1:0]  gain_reg;

    logic signed [tcf_pkg::ANGLE_W-1:0]  roll_est_reg, pitch_est_reg;
    logic signed [tcf_pkg::SAMPLE_W-1:0] ax_reg, gx_reg, gy_reg;
    logic signed [tcf_pkg::Z_W-1:0]      roll_acc_reg, pitch_acc_reg;
    logic signed [PROD_W-1:0]            prod_reg, mix_reg;
    logic signed [GYRO_W-1:0]            gyro_reg;

    logic                    result_valid_reg;
    tcf_pkg::angle_word_t    result_word_reg;

    logic                                 sample_fire, result_free;
    logic                                 cordic_start;
    logic signed [tcf_pkg::CORD_W-1:0]    cordic_x, cordic_y;
    logic signed [tcf_pkg::Z_W-1:0]       cordic_angle;
    logic signed [tcf_pkg::CORD_W-1:0]    cordic_mag;
    tcf_pkg::cordic_stat_t                cordic_stat;

    logic [tcf_pkg::BLEND_W-1:0]          alpha, alpha_inv;
    logic signed [MUL_A_W-1:0]            mul_a;
    logic signed [MUL_B_W-1:0]            mul_b;
    logic signed [PROD_W-1:0]             prod_next;
    logic                                 prod_load;
    logic signed [tcf_pkg::ANGLE_W-1:0]   est_sel;
    logic signed [tcf_pkg::SAMPLE_W-1:0]  rate_sel;
    logic signed [tcf_pkg::Z_W-1:0]       acc_sel;
    logic signed [GYRO_W-1:0]             est_wide;
    logic signed [PROD_W-1:0]             gyro_inc;
    logic signed [PROD_W-1:0]             mix_total;
    logic signed [tcf_pkg::ANGLE_W-1:0]   est_new;
    logic                                 in_cordic_state;
    logic                                 result_in_range;

    assign sample_fire  = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);
    assign result_free  = !result_valid_reg || result.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= tcf_pkg::BLEND_RESET;
            gain_reg  <= tcf_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (tcf_pkg::cfg_reg_t'(cfg_index))
                tcf_pkg::REG_BLEND_WEIGHT: blend_reg <= cfg_data[tcf_pkg::BLEND_W-1:0];
                tcf_pkg::REG_GYRO_GAIN:    gain_reg  <= cfg_data[tcf_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the gyro weight to one
    assign alpha     = (blend_reg > tcf_pkg::BLEND_W'(tcf_pkg::ALPHA_ONE)) ?
                       tcf_pkg::BLEND_W'(tcf_pkg::ALPHA_ONE) : blend_reg;
    assign alpha_inv = tcf_pkg::BLEND_W'(tcf_pkg::ALPHA_ONE) - alpha;

    // Shared CORDIC: roll from (az, ay), pitch from (den, -ax)
    assign cordic_start = sample_fire || (state_reg == ST_PITCH_START);
    assign cordic_x = (state_reg == ST_IDLE) ?
        (tcf_pkg::CORD_W'(sample.data.accel_z) <<< tcf_pkg::ACC_SHIFT) :
        $signed(prod_reg[DEN_SHIFT +: tcf_pkg::CORD_W]);
    assign cordic_y = (state_reg == ST_IDLE) ?
        (tcf_pkg::CORD_W'(sample.data.accel_y) <<< tcf_pkg::ACC_SHIFT) :
        -(tcf_pkg::CORD_W'(ax_reg) <<< tcf_pkg::ACC_SHIFT);

    tcf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (cordic_x),
        .y_in  (cordic_y),
        .angle (cordic_angle),
        .mag   (cordic_mag),
        .stat  (cordic_stat)
    );

    // Per-axis operand selection
    assign est_sel  = axis_reg ? pitch_est_reg : roll_est_reg;
    assign rate_sel = axis_reg ? gy_reg : gx_reg;
    assign acc_sel  = axis_reg ? pitch_acc_reg : roll_acc_reg;

    // Shared multiplier operands
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        prod_load = 1'b0;
        case (state_reg)
            ST_ROLL_CORDIC:
            begin
                mul_a     = cordic_mag;
                mul_b     = MUL_B_W'(tcf_pkg::INV_K_Q16);
                prod_load = 1'b1;
            end
            ST_GYRO_MUL:
            begin
                mul_a     = $signed(MUL_A_W'(gain_reg));
                mul_b     = MUL_B_W'(rate_sel);
                prod_load = 1'b1;
            end
            ST_MIX_GYRO:
            begin
                mul_a     = MUL_A_W'(gyro_reg);
                mul_b     = $signed(MUL_B_W'(alpha));
                prod_load = 1'b1;
            end
            ST_MIX_ACC:
            begin
                mul_a     = MUL_A_W'(acc_sel);
                mul_b     = $signed(MUL_B_W'(alpha_inv));
                prod_load = 1'b1;
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Gyro path: est * 8 plus the rounded rate increment
    assign est_wide = GYRO_W'(est_sel);
    assign gyro_inc = (prod_reg + GYRO_RND) >>> GYRO_SHIFT;

    // Blend, round to Q3.13 and saturate to +-pi
    assign mix_total = (mix_reg + prod_reg + MIX_RND) >>> MIX_SHIFT;
    always_comb
    begin
        if (mix_total > MIX_MAX)
            est_new = OUT_MAX;
        else if (mix_total < MIX_MIN)
            est_new = OUT_MIN;
        else
            est_new = $signed(mix_total[tcf_pkg::ANGLE_W-1:0]);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:         if (sample_fire) state_next = ST_ROLL_CORDIC;
            ST_ROLL_CORDIC:  if (cordic_stat.done) state_next = ST_PITCH_START;
            ST_PITCH_START:  state_next = ST_PITCH_CORDIC;
            ST_PITCH_CORDIC: if (cordic_stat.done) state_next = ST_GYRO_MUL;
            ST_GYRO_MUL:     state_next = ST_GYRO_SUM;
            ST_GYRO_SUM:     state_next = ST_MIX_GYRO;
            ST_MIX_GYRO:     state_next = ST_MIX_ACC;
            ST_MIX_ACC:      state_next = ST_FINISH;
            ST_FINISH:       state_next = axis_reg ? ST_DELIVER : ST_GYRO_MUL;
            ST_DELIVER:      if (result_free) state_next = ST_IDLE;
            default:         state_next = ST_IDLE;
        endcase
    end

    // Control state, estimates and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            axis_reg         <= 1'b0;
            roll_est_reg     <= '0;
            pitch_est_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_PITCH_CORDIC)
                axis_reg <= 1'b0;
            else if (state_reg == ST_FINISH)
                axis_reg <= 1'b1;

            if (state_reg == ST_FINISH)
            begin
                if (axis_reg)
                    pitch_est_reg <= est_new;
                else
                    roll_est_reg <= est_new;
            end

            if ((state_reg == ST_DELIVER) && result_free)
                result_valid_reg <= 1'b1;
            else if (result.ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            ax_reg <= sample.data.accel_x;
            gx_reg <= sample.data.rate_x;
            gy_reg <= sample.data.rate_y;
        end
        if ((state_reg == ST_ROLL_CORDIC) && cordic_stat.done)
            roll_acc_reg <= cordic_angle;
        if ((state_reg == ST_PITCH_CORDIC) && cordic_stat.done)
            pitch_acc_reg <= cordic_angle;
        if (prod_load)
            prod_reg <= prod_next;
        if (state_reg == ST_GYRO_SUM)
            gyro_reg <= (est_wide <<< 3) + $signed(gyro_inc[GYRO_W-1:0]);
        if (state_reg == ST_MIX_ACC)
            mix_reg <= prod_reg;
        if ((state_reg == ST_DELIVER) && result_free)
        begin
            result_word_reg.roll_angle  <= roll_est_reg;
            result_word_reg.pitch_angle <= pitch_est_reg;
        end
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_word_reg;

    // Check terms
    assign in_cordic_state = (state_reg == ST_ROLL_CORDIC) || (state_reg == ST_PITCH_CORDIC);
    assign result_in_range = (result.data.roll_angle <= OUT_MAX) &&
                             (result.data.roll_angle >= OUT_MIN) &&
                             (result.data.pitch_angle <= OUT_MAX) &&
                             (result.data.pitch_angle >= OUT_MIN);

    // Checks
    `TCF_ASSERT_NEXT(a_busy_after_accept, sample_fire, !sample.ready)
    `TCF_ASSERT_IMP(a_no_accept_in_cordic, cordic_stat.busy, !sample.ready)
    `TCF_ASSERT_IMP(a_done_when_waited, cordic_stat.done, in_cordic_state)
    `TCF_ASSERT_IMP(a_result_in_range, result.valid, result_in_range)

endmodule

// File: bench/tb_tilt_complementary_filter.sv
// ============================================================================
// Tilt complementary filter testbench
// Drives accelerometer/gyro sample words through the filter and checks every
// roll/pitch word against a cycle-free fixed-point model of the block or the
// angles typed in its row. A short directed table comes first (reset state,
// vector quadrants, sample extremes, saturation, oversized weight, zero gain).
// Random phases follow, each under its own register setting, with random
// idling on both channels and one long receiver hold-off.
// ============================================================================
`timescale 1ns / 100ps

module tb_tilt_complementary_filter;

    // Model constants
    localparam int     STEPS       = 16;
    localparam longint HALF_TURN   = 205887;
    localparam longint INV_GAIN    = 39797;
    localparam longint ANGLE_MAX   = 25736;
    localparam longint UNITY       = 65536;
    localparam longint GYRO_ROUND  = longint'(1) << 28;
    localparam longint BLEND_ROUND = longint'(1) << 18;
    localparam longint ATAN_STEPS_Q16 [0:23] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    // Run shape
    localparam int PHASES         = 6;
    localparam int WORDS_PER_PH   = 73;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 2 * STEPS + 13 + 8;
    localparam int CYCLE_LIMIT    = 400000;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        tcf_pkg::cfg_reg_t     reg_sel;
        logic [31:0]           value;
        tcf_pkg::sample_word_t word;
        tcf_pkg::angle_word_t  angles;
    } dir_row_t;

    localparam int DIR_LEN = 25;
    localparam dir_row_t DIR_ROWS [0:DIR_LEN-1] = '{
        // reset state, zero vector
        '{ROW_TYPED,     tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, 0, 0, 0, 0}, '{0, 0}},
        // level, roll +90, roll -90
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, 0, 16384, 0, 0}, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, 16384, 0, 0, 0}, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, -16384, 0, 0, 0}, '0},
        // upside down: negative x with y at zero and just below it
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, 0, -16384, 0, 0}, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, -1, -16384, 0, 0}, '0},
        // pitch down and up
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{16384, 0, 0, 0, 0}, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{-16384, 0, 0, 0, 0}, '0},
        // field extremes
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{-32768, 32767, -32768, 32767, -32768}, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{32767, -32768, 32767, -32768, 32767}, '0},
        // accelerometer only
        '{ROW_CFG,       tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '0, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{-32768, -32768, -32768, 1000, -1000}, '0},
        '{ROW_TYPED,     tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, 0, 0, 0, 0}, '{0, 0}},
        // gyro only at full gain: both angles saturate and stay there
        '{ROW_CFG,       tcf_pkg::REG_BLEND_WEIGHT, 32'd65536, '0, '0},
        '{ROW_CFG,       tcf_pkg::REG_GYRO_GAIN,    32'hFFFF_FFFF, '0, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0, '{0, 0, 0, 32767, -32768}, '0},
        '{ROW_TYPED,     tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{0, 0, 0, 32767, -32768}, '{25736, -25736}},
        // oversized weight acts as pure gyro
        '{ROW_CFG,       tcf_pkg::REG_BLEND_WEIGHT, 32'hFFFF_FFFF, '0, '0},
        '{ROW_TYPED,     tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{100, -200, 300, 32767, -32768}, '{25736, -25736}},
        // zero gain with pure gyro holds the estimate
        '{ROW_CFG,       tcf_pkg::REG_GYRO_GAIN,    32'd0, '0, '0},
        '{ROW_CFG,       tcf_pkg::REG_BLEND_WEIGHT, 32'd65537, '0, '0},
        '{ROW_TYPED,     tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{-32768, 32767, 32767, -32768, 32767}, '{25736, -25736}},
        // even mix at nominal gain
        '{ROW_CFG,       tcf_pkg::REG_BLEND_WEIGHT, 32'd32768, '0, '0},
        '{ROW_CFG,       tcf_pkg::REG_GYRO_GAIN,    32'd4687620, '0, '0},
        '{ROW_PREDICTED, tcf_pkg::REG_BLEND_WEIGHT, 32'd0,
          '{1000, -2000, 15000, -300, 450}, '0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tcf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tcf_pkg::CFG_DATA_W-1:0]  cfg_data;

    tcf_stream_if #(.payload_t(tcf_pkg::sample_word_t)) sample_ch ();
    tcf_stream_if #(.payload_t(tcf_pkg::angle_word_t))  result_ch ();

    // Model state and registers
    logic signed [15:0] roll_est;
    logic signed [15:0] pitch_est;
    logic [16:0]        blend_reg;
    logic [31:0]        gain_reg;

    tcf_pkg::angle_word_t pending_angles [$];
    int          errors;
    int          words_sent;
    int          words_checked;
    int          reg_writes;
    int          cycle_count;
    bit          steady_in;
    bit          steady_out;
    bit          long_hold_req;

    tilt_complementary_filter #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Vectoring CORDIC: angle of (x, y) in Q.16 radians, scaled magnitude out
    function automatic longint vector_angle(input longint xin, input longint yin,
                                            output longint mag);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = xin;
        y = yin;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        // fold the left half plane onto the right, preload +-pi
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEPS_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEPS_Q16[i];
            end
        end
        mag = x;
        return z;
    endfunction

    // Gyro-integrated estimate blended with the accelerometer tilt, saturated
    function automatic logic signed [15:0] fuse_angle(input longint est, input longint rate,
                                                      input longint acc, input longint alpha);
        longint gyro;
        longint mix;
        longint fused;
        gyro  = est * 8 + ((rate * longint'({32'b0, gain_reg}) + GYRO_ROUND) >>> 29);
        mix   = alpha * gyro + (UNITY - alpha) * acc;
        fused = (mix + BLEND_ROUND) >>> 19;
        if (fused > ANGLE_MAX)
            fused = ANGLE_MAX;
        if (fused < -ANGLE_MAX)
            fused = -ANGLE_MAX;
        return fused[15:0];
    endfunction

    // Advance the model by one sample word and return the new angles
    function automatic tcf_pkg::angle_word_t predict_angles(input tcf_pkg::sample_word_t w);
        longint               mag;
        longint               spare_mag;
        longint               roll_acc;
        longint               pitch_acc;
        longint               den;
        longint               alpha;
        tcf_pkg::angle_word_t a;
        alpha     = (blend_reg > 17'd65536) ? UNITY : longint'({47'b0, blend_reg});
        roll_acc  = vector_angle(longint'(w.accel_z) * 16384, longint'(w.accel_y) * 16384, mag);
        den       = (mag * INV_GAIN) >>> 16;
        pitch_acc = vector_angle(den, -longint'(w.accel_x) * 16384, spare_mag);
        roll_est  = fuse_angle(roll_est, longint'(w.rate_x), roll_acc, alpha);
        pitch_est = fuse_angle(pitch_est, longint'(w.rate_y), pitch_acc, alpha);
        a.roll_angle  = roll_est;
        a.pitch_angle = pitch_est;
        return a;
    endfunction

    function automatic logic signed [15:0] span16(input int lim);
        return 16'($urandom_range(0, 2 * lim)) - 16'(lim);
    endfunction

    function automatic logic signed [15:0] extreme16();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Mostly plausible motion, the rest raw noise, extremes and free fall
    function automatic tcf_pkg::sample_word_t random_word();
        tcf_pkg::sample_word_t w;
        case ($urandom_range(0, 9))
            6, 7:
            begin
                w = tcf_pkg::sample_word_t'({$urandom, $urandom, 16'($urandom)});
            end
            8:
            begin
                w.accel_x = extreme16();
                w.accel_y = extreme16();
                w.accel_z = extreme16();
                w.rate_x  = extreme16();
                w.rate_y  = extreme16();
            end
            9:
            begin
                w.accel_x = 0;
                w.accel_y = 0;
                w.accel_z = 0;
                w.rate_x  = span16(4000);
                w.rate_y  = span16(4000);
            end
            default:
            begin
                w.accel_x = span16(20000);
                w.accel_y = span16(20000);
                w.accel_z = span16(20000);
                w.rate_x  = span16(2000);
                w.rate_y  = span16(2000);
            end
        endcase
        return w;
    endfunction

    // Offer one word after a random gap, none if steady, and log its expected angles on accept
    task automatic send_word(input tcf_pkg::sample_word_t w, input bit typed,
                             input tcf_pkg::angle_word_t typed_angles);
        int                   gap;
        tcf_pkg::angle_word_t predicted;
        gap = steady_in ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.data  <= w;
        sample_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = predict_angles(w);
        pending_angles.push_back(typed ? typed_angles : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // Drain the block, then write one register
    task automatic write_register(input tcf_pkg::cfg_reg_t sel, input logic [31:0] value);
        sample_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (sel)
            tcf_pkg::REG_BLEND_WEIGHT: blend_reg = value[16:0];
            tcf_pkg::REG_GYRO_GAIN:    gain_reg  = value;
            default:                   ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] phase_blend(input int ph);
        case (ph)
            0:       return 32'd3277;
            1:       return 32'd0;
            2:       return 32'd65536;
            3:       return $urandom_range(0, 65536);
            4:       return $urandom;
            default: return $urandom_range(30000, 65535);
        endcase
    endfunction

    function automatic logic [31:0] phase_gain(input int ph);
        case (ph)
            0:       return 32'd4687620;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0;
            3:       return $urandom;
            4:       return $urandom_range(0, 20000000);
            default: return $urandom;
        endcase
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls unless steady, one long hold-off on request
    initial
    begin : angle_sink
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = steady_out ? 0 : $urandom_range(0, 15);
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    // Compare each taken word with the oldest expected one
    always @(posedge clk)
    begin : angle_check
        tcf_pkg::angle_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_angles.size() == 0)
            begin
                errors++;
                $display("%0t: angle word with nothing pending, got roll %0d pitch %0d",
                         $time, result_ch.data.roll_angle, result_ch.data.pitch_angle);
            end
            else
            begin
                want = pending_angles.pop_front();
                words_checked++;
                if (result_ch.data.roll_angle !== want.roll_angle)
                begin
                    errors++;
                    $display("%0t: roll mismatch, expected %0d, got %0d",
                             $time, want.roll_angle, result_ch.data.roll_angle);
                end
                if (result_ch.data.pitch_angle !== want.pitch_angle)
                begin
                    errors++;
                    $display("%0t: pitch mismatch, expected %0d, got %0d",
                             $time, want.pitch_angle, result_ch.data.pitch_angle);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        errors          = 0;
        words_sent      = 0;
        words_checked   = 0;
        reg_writes      = 0;
        steady_in       = 1'b0;
        steady_out      = 1'b0;
        long_hold_req   = 1'b0;
        roll_est        = '0;
        pitch_est       = '0;
        blend_reg       = tcf_pkg::BLEND_RESET;
        gain_reg        = tcf_pkg::GAIN_RESET;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= tcf_pkg::REG_BLEND_WEIGHT;
        cfg_data        <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (int i = 0; i < DIR_LEN; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_register(DIR_ROWS[i].reg_sel, DIR_ROWS[i].value);
            else
                send_word(DIR_ROWS[i].word, DIR_ROWS[i].kind == ROW_TYPED,
                          DIR_ROWS[i].angles);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_register(tcf_pkg::REG_BLEND_WEIGHT, phase_blend(ph));
            write_register(tcf_pkg::REG_GYRO_GAIN, phase_gain(ph));
            steady_in  = (ph == 2);
            steady_out = (ph == 2) || (ph == 4);
            if (ph == 3)
                long_hold_req = 1'b1;
            repeat (WORDS_PER_PH) send_word(random_word(), 1'b0, '0);
        end

        // Drain and let any stray word show up
        sample_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d sample words over %0d register writes; %0d angle words checked.",
                 words_sent, reg_writes, words_checked);
        $display("Mismatches or stray words: %0d.", errors);
        if (errors == 0 && pending_angles.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tcf_pkg.sv
rtl/tcf_stream_if.sv
rtl/tcf_cordic.sv
rtl/tilt_complementary_filter.sv
bench/tb_tilt_complementary_filter.sv
